// ===== rtl/core/mhd_pkg.sv =====
package mhd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_REG_W = 13;
   localparam int WX_W        = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;
   localparam int HEIGHT_W    = 16;
   localparam int COUNT_W     = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 4;
   localparam int COLOR_CHAN  = 3;
   localparam int LIN_W       = 16;
   localparam int LIN_DEPTH   = 256;
   localparam int SRGB_AW     = 12;
   localparam int SRGB_DEPTH  = 4096;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pix_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_WIDTH,
      REG_SOURCE_HEIGHT,
      REG_CHANNEL_COUNT,
      REG_SRGB_MODE
   } csr_index_type;

   localparam logic [63:0] QONE     = 64'd1 << 30;
   localparam logic [63:0] QHALF    = 64'd1 << 29;
   localparam logic [63:0] SRGB_DIV = 64'd1000 << 30;

   // Q30 helpers, used only to build the conversion tables at elaboration
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      return (a * b + QHALF) >> 30;
   endfunction

   function automatic logic [63:0] qpow(input logic [63:0] v, input int k);
      logic [63:0] v2;
      logic [63:0] v4;
      v2 = qmul(v, v);
      v4 = qmul(v2, v2);
      if (k == 5) begin
         return qmul(v4, v);
      end
      return qmul(qmul(v4, v4), v4);
   endfunction

   function automatic logic [63:0] qroot(input logic [63:0] target, input int k);
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      lo = 64'd0;
      hi = QONE;
      while (lo < hi) begin
         mid = lo + ((hi - lo + 64'd1) >> 1);
         if (qpow(mid, k) <= target) begin
            lo = mid;
         end else begin
            hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

   function automatic logic [LIN_W-1:0] lin_entry(input int idx);
      logic [63:0] i;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] lin;
      i = 64'(idx);
      if (i <= 64'd10) begin
         return LIN_W'((i * 64'd1310400 + 64'd32946) / 64'd65892);
      end
      x   = ((64'd1000 * i + 64'd14025) * QONE + 64'd134512) / 64'd269025;
      x2  = qmul(x, x);
      lin = qmul(x2, qroot(x2, 5));
      return LIN_W'((lin * 64'd65520 + QHALF) >> 30);
   endfunction

   function automatic logic [CHAN_W-1:0] srgb_entry(input int idx);
      logic [63:0] i;
      logic [63:0] l;
      logic [63:0] t;
      logic [63:0] num;
      logic [63:0] base;
      logic [63:0] v;
      i = 64'(idx);
      if (i <= 64'd12) begin
         return CHAN_W'((i * 64'd65892 + 64'd40950) / 64'd81900);
      end
      l    = (i * QONE + 64'd2047) / 64'd4095;
      t    = qpow(qroot(l, 12), 5);
      num  = 64'd269025 * t;
      base = 64'd13525 << 30;
      v    = 64'd0;
      if (num > base) begin
         v = (num - base) / SRGB_DIV;
      end
      if (v > 64'd255) begin
         v = 64'd255;
      end
      return CHAN_W'(v);
   endfunction

endpackage

// ===== rtl/core/mhd_req_if.sv =====
interface mhd_req_if;
   logic                      valid;
   logic                      ready;
   logic [mhd_pkg::CHAN_W-1:0] in_chan0;
   logic [mhd_pkg::CHAN_W-1:0] in_chan1;
   logic [mhd_pkg::CHAN_W-1:0] in_chan2;
   logic [mhd_pkg::CHAN_W-1:0] in_chan3;

   modport source (output valid, output in_chan0, output in_chan1, output in_chan2,
                   output in_chan3, input ready);
   modport sink   (input valid, input in_chan0, input in_chan1, input in_chan2,
                   input in_chan3, output ready);
endinterface

// ===== rtl/core/mhd_rsp_if.sv =====
interface mhd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [mhd_pkg::CHAN_W-1:0] out_chan0;
   logic [mhd_pkg::CHAN_W-1:0] out_chan1;
   logic [mhd_pkg::CHAN_W-1:0] out_chan2;
   logic [mhd_pkg::CHAN_W-1:0] out_chan3;
   logic                      last_of_level;

   modport source (output valid, output out_chan0, output out_chan1, output out_chan2,
                   output out_chan3, output last_of_level, input ready);
   modport sink   (input valid, input out_chan0, input out_chan1, input out_chan2,
                   input out_chan3, input last_of_level, output ready);
endinterface

// ===== rtl/core/mip_half_downsampler_core.sv =====
// 2x2 box-filter mip downsampler. Source pixels enter in raster order on req_ch, one word
// per cycle sustained while rsp_ch back-pressure does not stall the pipeline; each 2x2 group
// gives one half-size pixel that rsp_ch holds valid after its bottom-right pixel is accepted,
// having passed line-store read, to-linear lookup, sum and to-sRGB ROM read, output register.
// The even row of each pair is held in a line store of MAX_WIDTH words with one write and
// two registered reads per cycle; its contents are not cleared at reset and need no clearing
// pass. Registers are to be written on csr_we by the user only while no word is in flight;
// the block itself does not enforce this. Any write to a defined index restarts the level.
// last_of_level marks the final pixel of a level.
module mip_half_downsampler_core (
   input  logic                            clock,
   input  logic                            reset,
   mhd_req_if.sink                         req_ch,
   mhd_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [mhd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mhd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mhd_pkg::*;

   // configuration
   logic [WIDTH_REG_W-1:0] width_ff;
   logic [HEIGHT_W-1:0]    height_ff;
   logic [COUNT_W-1:0]     count_ff;
   logic                   srgb_ff;

   logic [WX_W-1:0]        w_eff;
   logic [HEIGHT_W-1:0]    h_eff;
   logic [COUNT_W-1:0]     nch;
   logic                   w1;
   logic                   h1;
   logic                   csr_hit;

   always_comb begin
      if (width_ff == '0) begin
         w_eff = WX_W'(1);
      end else if (WX_W'(width_ff) > WX_W'(MAX_WIDTH)) begin
         w_eff = WX_W'(MAX_WIDTH);
      end else begin
         w_eff = WX_W'(width_ff);
      end
      h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
      if (count_ff == '0) begin
         nch = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(NUM_CHAN)) begin
         nch = COUNT_W'(NUM_CHAN);
      end else begin
         nch = count_ff;
      end
   end

   assign w1 = (w_eff == WX_W'(1));
   assign h1 = (h_eff == HEIGHT_W'(1));

   always_comb begin
      unique case (csr_index)
         REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_CHANNEL_COUNT, REG_SRGB_MODE: csr_hit = csr_we;
         default: csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_REG_W'(1);
         height_ff <= HEIGHT_W'(1);
         count_ff  <= COUNT_W'(NUM_CHAN);
         srgb_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:  width_ff  <= csr_wdata[WIDTH_REG_W-1:0];
            REG_SOURCE_HEIGHT: height_ff <= csr_wdata[HEIGHT_W-1:0];
            REG_CHANNEL_COUNT: count_ff  <= csr_wdata[COUNT_W-1:0];
            REG_SRGB_MODE:     srgb_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_en, s2_en, s3_en, out_en;

   assign out_en = !rsp_valid_ff || rsp_ch.ready;
   assign s3_en  = !s3_valid_ff || out_en;
   assign s2_en  = !s2_valid_ff || s3_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   // position tracking
   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   pix_type             prev_ff;
   pix_type             pix;
   logic                row_even;
   logic                emit;
   logic                last_x, last_y;
   logic [COL_W-1:0]    col_l;
   logic                accept;
   logic [WX_W-1:0]     col_plus;
   logic [HEIGHT_W:0]   row_plus;

   assign pix      = {req_ch.in_chan3, req_ch.in_chan2, req_ch.in_chan1, req_ch.in_chan0};
   assign row_even = !row_ff[0];
   assign emit     = (w1 || col_ff[0]) && (!row_even || h1);
   assign col_l    = w1 ? col_ff : col_ff - COL_W'(1);
   assign last_x   = w1 || (WX_W'(col_ff >> 1) == (w_eff >> 1) - WX_W'(1));
   assign last_y   = h1 || ((row_ff >> 1) == (h_eff >> 1) - HEIGHT_W'(1));
   assign req_ch.ready = s1_en || !emit;
   assign accept   = req_ch.valid && req_ch.ready;
   assign col_plus = WX_W'(col_ff) + WX_W'(1);
   assign row_plus = {1'b0, row_ff} + (HEIGHT_W+1)'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_plus >= w_eff) begin
            col_in = '0;
            row_in = (row_plus >= {1'b0, h_eff}) ? '0 : row_plus[HEIGHT_W-1:0];
         end else begin
            col_in = col_plus[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         col_ff  <= '0;
         row_ff  <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else if (accept) begin
         prev_ff <= pix;
      end
   end

   // line store
   logic [NUM_CHAN*CHAN_W-1:0] line_mem [MAX_WIDTH];
   pix_type                    ls_rd0_ff, ls_rd1_ff;

   always_ff @(posedge clock) begin
      if (accept && row_even) begin
         line_mem[col_ff] <= pix;
      end
      if (accept && emit) begin
         ls_rd0_ff <= line_mem[col_l];
         ls_rd1_ff <= line_mem[col_ff];
      end
   end

   // stage 1: gather the group, to-linear lookup
   pix_type s1_pix_ff, s1_prev_ff;
   logic    s1_row_even_ff, s1_w1_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= accept && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         s1_pix_ff      <= pix;
         s1_prev_ff     <= prev_ff;
         s1_row_even_ff <= row_even;
         s1_w1_ff       <= w1;
         s1_last_ff     <= last_x && last_y;
      end
   end

   logic [LIN_W-1:0] lin_tab [LIN_DEPTH];

   for (genvar g = 0; g < LIN_DEPTH; g++) begin : g_lin
      localparam logic [LIN_W-1:0] Entry = lin_entry(g);
      assign lin_tab[g] = Entry;
   end

   pix_type          q [NUM_CHAN];
   logic [LIN_W-1:0] lin_in [COLOR_CHAN][NUM_CHAN];

   always_comb begin
      q[0] = s1_row_even_ff ? (s1_w1_ff ? s1_pix_ff : s1_prev_ff) : ls_rd0_ff;
      q[1] = s1_row_even_ff ? s1_pix_ff : ls_rd1_ff;
      q[2] = s1_w1_ff ? s1_pix_ff : s1_prev_ff;
      q[3] = s1_pix_ff;
      for (int c = 0; c < COLOR_CHAN; c++) begin
         for (int k = 0; k < NUM_CHAN; k++) begin
            lin_in[c][k] = lin_tab[q[k][c]];
         end
      end
   end

   // stage 2: sums, table index
   pix_type          s2_q_ff [NUM_CHAN];
   logic [LIN_W-1:0] s2_lin_ff [COLOR_CHAN][NUM_CHAN];
   logic             s2_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_q_ff    <= q;
         s2_lin_ff  <= lin_in;
         s2_last_ff <= s1_last_ff;
      end
   end

   logic [LIN_W+2:0]    lin_sum [COLOR_CHAN];
   logic [SRGB_AW-1:0]  srgb_idx [COLOR_CHAN];
   logic [CHAN_W+1:0]   byte_sum [NUM_CHAN];
   logic [CHAN_W-1:0]   avg [NUM_CHAN];

   always_comb begin
      for (int c = 0; c < COLOR_CHAN; c++) begin
         lin_sum[c] = (LIN_W+3)'(s2_lin_ff[c][0]) + (LIN_W+3)'(s2_lin_ff[c][1])
                    + (LIN_W+3)'(s2_lin_ff[c][2]) + (LIN_W+3)'(s2_lin_ff[c][3])
                    + (LIN_W+3)'(32);
         if ((lin_sum[c] >> 6) > (LIN_W+3)'(SRGB_DEPTH - 1)) begin
            srgb_idx[c] = SRGB_AW'(SRGB_DEPTH - 1);
         end else begin
            srgb_idx[c] = lin_sum[c][SRGB_AW+5:6];
         end
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
         byte_sum[c] = (CHAN_W+2)'(s2_q_ff[0][c]) + (CHAN_W+2)'(s2_q_ff[1][c])
                     + (CHAN_W+2)'(s2_q_ff[2][c]) + (CHAN_W+2)'(s2_q_ff[3][c])
                     + (CHAN_W+2)'(2);
         avg[c] = byte_sum[c][CHAN_W+1:2];
      end
   end

   // stage 3: to-sRGB ROM read, one copy per color channel
   logic [CHAN_W-1:0] srgb_tab [SRGB_DEPTH];
   logic [CHAN_W-1:0] srgb_rd_ff [COLOR_CHAN];
   logic [CHAN_W-1:0] s3_avg_ff [NUM_CHAN];
   logic              s3_last_ff;

   for (genvar g = 0; g < SRGB_DEPTH; g++) begin : g_srgb
      localparam logic [CHAN_W-1:0] Entry = srgb_entry(g);
      assign srgb_tab[g] = Entry;
   end

   for (genvar ch = 0; ch < COLOR_CHAN; ch++) begin : g_rom
      logic [CHAN_W-1:0] srgb_rom [SRGB_DEPTH];
      assign srgb_rom = srgb_tab;
      always_ff @(posedge clock) begin
         if (s3_en) begin
            srgb_rd_ff[ch] <= srgb_rom[srgb_idx[ch]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_avg_ff  <= avg;
         s3_last_ff <= s2_last_ff;
      end
   end

   // output register
   pix_type out_in, out_ff;
   logic    out_last_ff;

   always_comb begin
      for (int c = 0; c < COLOR_CHAN; c++) begin
         if (COUNT_W'(c) >= nch) begin
            out_in[c] = '0;
         end else if (srgb_ff) begin
            out_in[c] = srgb_rd_ff[c];
         end else begin
            out_in[c] = s3_avg_ff[c];
         end
      end
      out_in[NUM_CHAN-1] = (nch == COUNT_W'(NUM_CHAN)) ? s3_avg_ff[NUM_CHAN-1] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ff      <= out_in;
         out_last_ff <= s3_last_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_chan0     = out_ff[0];
   assign rsp_ch.out_chan1     = out_ff[1];
   assign rsp_ch.out_chan2     = out_ff[2];
   assign rsp_ch.out_chan3     = out_ff[3];
   assign rsp_ch.last_of_level = out_last_ff;

endmodule

// ===== rtl/core/mhd_checker.sv =====
module mhd_checker (
   input logic                                          clock,
   input logic                                          reset,
   input logic                                          req_valid,
   input logic                                          req_ready,
   input logic                                          rsp_valid,
   input logic                                          rsp_ready,
   input logic [mhd_pkg::NUM_CHAN*mhd_pkg::CHAN_W:0]    rsp_word
);
   import mhd_pkg::*;

   logic seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         seen_ff <= 1'b1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_ff)
      else $error("result word without any accepted pixel");

endmodule

bind mip_half_downsampler_core mhd_checker u_mhd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_word  ({rsp_ch.last_of_level, rsp_ch.out_chan3, rsp_ch.out_chan2,
                rsp_ch.out_chan1, rsp_ch.out_chan0})
);
